>>> src/conv2d_3x3_relu_stream_assert.svh
// Assertion macros for the checker file.
`ifndef CONV2D_3X3_RELU_STREAM_ASSERT_SVH
`define CONV2D_3X3_RELU_STREAM_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define C3R_ASSERT_NOW(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define C3R_ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/c3r_pkg.sv
package c3r_pkg;

    localparam int KERNEL_SIDE = 3;
    localparam int PIX_W       = 8;
    localparam int WGT_W       = 8;
    localparam int PROD_W      = PIX_W + 1 + WGT_W;   // unsigned pixel x signed weight
    localparam int COL_W       = PROD_W + 2;          // sum of one kernel column
    localparam int SUM_W       = COL_W + 1;           // sum of the whole kernel
    localparam int ACT_W       = 18;
    localparam int ACT_MAX     = 146880;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = KERNEL_SIDE * WGT_W;
    localparam int SIZE_W      = 11;
    localparam int IN_TDATA_W  = ((PIX_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((ACT_W + 7) / 8) * 8;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WEIGHTS_ROW0 = 2'd0,
        REG_WEIGHTS_ROW1 = 2'd1,
        REG_WEIGHTS_ROW2 = 2'd2,
        REG_IMAGE_SIZE   = 2'd3
    } t_cfg_reg;

    // one window column, index 0 is the top kernel row
    typedef logic [KERNEL_SIDE-1:0][PIX_W-1:0] t_pix_col;
    typedef logic [KERNEL_SIDE-1:0][WGT_W-1:0] t_wgt_col;

    typedef struct packed {
        logic shift;   // a pixel transaction enters the window
        logic adv;     // the product stage advances
    } t_cell_ctrl;

endpackage

>>> src/c3r_ram.sv
module c3r_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/c3r_cell.sv
// One window column: three pixels, their products with the matching weight
// column, and a link in the partial-sum chain across the window.
module c3r_cell (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  c3r_pkg::t_cell_ctrl                   i_ctrl,
    input  c3r_pkg::t_pix_col                     i_pix,
    input  c3r_pkg::t_wgt_col                     i_wgt,
    input  logic signed [c3r_pkg::SUM_W-1:0]      i_psum,
    output c3r_pkg::t_pix_col                     o_pix,
    output logic signed [c3r_pkg::SUM_W-1:0]      o_psum
);

    c3r_pkg::t_pix_col                      r_pix;
    logic signed [c3r_pkg::COL_W-1:0]       r_sum;
    logic signed [c3r_pkg::COL_W-1:0]       n_sum;
    logic signed [c3r_pkg::PROD_W-1:0]      prod [c3r_pkg::KERNEL_SIDE];

    always_comb begin
        n_sum = '0;
        for (int k = 0; k < c3r_pkg::KERNEL_SIDE; k++) begin
            prod[k] = $signed({1'b0, r_pix[k]}) * $signed(i_wgt[k]);
            n_sum   = n_sum + c3r_pkg::COL_W'(prod[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix <= '0;
        end else if (i_ctrl.shift) begin
            r_pix <= i_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.adv) begin
            r_sum <= n_sum;
        end
    end

    assign o_pix  = r_pix;
    assign o_psum = i_psum + c3r_pkg::SUM_W'(r_sum);

endmodule

>>> src/conv2d_3x3_relu_stream.sv
// 3x3 valid-mode convolution with ReLU over a square image streamed in raster
// order, one 8-bit pixel per transaction. The block takes one pixel every
// cycle while the skid slot is empty; a result is registered in turn by the
// pixel registers of the three window cells, their product registers and the
// output register. Pixels at row or column 0 and 1 give no result; the others
// give max(0, sum of pixel x weight) as a plain integer, saturated at 146880, and
// the frame's final result carries tlast. Weights are three signed bytes per
// kernel row (column 0 in the low byte); image_size is clamped to 3..MAX_SIDE.
// Write configuration only while no transaction is in flight. The line stores
// are not cleared after reset: contents of rows never written are unused.
module conv2d_3x3_relu_stream #(
    parameter int MAX_SIDE = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [c3r_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [c3r_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    // pixel input
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [c3r_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // [7:0] pixel
    // result output
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [c3r_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // [17:0] activation, rest 0
    output logic                                m_axis_tlast    // last
);

    localparam int CNT_W    = $clog2(MAX_SIDE);
    localparam int SIDE_RST = (MAX_SIDE < 5) ? MAX_SIDE - 1 : 4;
    localparam int KS       = c3r_pkg::KERNEL_SIDE;
    localparam int PIX_W    = c3r_pkg::PIX_W;
    localparam int WGT_W    = c3r_pkg::WGT_W;
    localparam int SUM_W    = c3r_pkg::SUM_W;
    localparam int ACT_W    = c3r_pkg::ACT_W;

    // configuration
    logic [c3r_pkg::CFG_DATA_W-1:0] r_wgt [KS];
    logic [CNT_W-1:0]               r_side_last;
    logic [c3r_pkg::SIZE_W-1:0]     cfg_size;
    logic [CNT_W-1:0]               n_side_last;

    assign cfg_size = i_cfg_wdata[c3r_pkg::SIZE_W-1:0];

    always_comb begin
        if (int'(cfg_size) < KS) begin
            n_side_last = CNT_W'(KS - 1);
        end else if (int'(cfg_size) > MAX_SIDE) begin
            n_side_last = CNT_W'(MAX_SIDE - 1);
        end else begin
            n_side_last = CNT_W'(int'(cfg_size) - 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < KS; m++) begin
                r_wgt[m] <= '0;
            end
            r_side_last <= CNT_W'(SIDE_RST);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                c3r_pkg::REG_WEIGHTS_ROW0: r_wgt[0]    <= i_cfg_wdata;
                c3r_pkg::REG_WEIGHTS_ROW1: r_wgt[1]    <= i_cfg_wdata;
                c3r_pkg::REG_WEIGHTS_ROW2: r_wgt[2]    <= i_cfg_wdata;
                c3r_pkg::REG_IMAGE_SIZE:   r_side_last <= n_side_last;
                default: ;
            endcase
        end
    end

    // flow control: everything advances unless the skid slot is holding a result
    logic r_skid_valid;
    logic en;
    logic accept;

    assign en            = !r_skid_valid;
    assign s_axis_tready = en;
    assign accept        = s_axis_tvalid && en;

    // raster position
    logic [CNT_W-1:0] r_col, r_row, n_col, n_row;
    logic             col_wrap, row_wrap;

    assign col_wrap = r_col >= r_side_last;
    assign row_wrap = r_row >= r_side_last;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (col_wrap) begin
                n_col = '0;
                n_row = row_wrap ? '0 : r_row + CNT_W'(1);
            end else begin
                n_col = r_col + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // line stores: read ahead at the next pixel's column
    logic [PIX_W-1:0] pixel, above1, above2;

    assign pixel = s_axis_tdata[PIX_W-1:0];

    c3r_ram #(.WIDTH(PIX_W), .DEPTH(MAX_SIDE)) u_line_a (
        .i_clk  (i_clk),
        .i_we   (accept),
        .i_waddr(r_col),
        .i_wdata(pixel),
        .i_raddr(n_col),
        .o_rdata(above1)
    );

    c3r_ram #(.WIDTH(PIX_W), .DEPTH(MAX_SIDE)) u_line_b (
        .i_clk  (i_clk),
        .i_we   (accept),
        .i_waddr(r_col),
        .i_wdata(above1),
        .i_raddr(n_col),
        .o_rdata(above2)
    );

    // window stage and product stage tags
    logic r_va, r_la, r_vb, r_lb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (en) begin
            r_va <= accept && (r_row >= CNT_W'(2)) && (r_col >= CNT_W'(2));
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_la <= row_wrap && col_wrap;
            r_lb <= r_la;
        end
    end

    // chain of window cells; cell KS-1 takes the newest column
    c3r_pkg::t_cell_ctrl     cell_ctrl;
    c3r_pkg::t_pix_col       cell_in  [KS];
    c3r_pkg::t_pix_col       cell_out [KS];
    c3r_pkg::t_wgt_col       cell_wgt [KS];
    logic signed [SUM_W-1:0] psum     [KS+1];

    assign cell_ctrl.shift = accept;
    assign cell_ctrl.adv   = en;
    assign psum[0]         = '0;

    for (genvar n = 0; n < KS; n++) begin : g_cell
        if (n == KS - 1) begin : g_head
            assign cell_in[n] = {pixel, above1, above2};
        end else begin : g_link
            assign cell_in[n] = cell_out[n+1];
        end
        for (genvar m = 0; m < KS; m++) begin : g_wgt
            assign cell_wgt[n][m] = r_wgt[m][WGT_W*n +: WGT_W];
        end

        c3r_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctrl (cell_ctrl),
            .i_pix  (cell_in[n]),
            .i_wgt  (cell_wgt[n]),
            .i_psum (psum[n]),
            .o_pix  (cell_out[n]),
            .o_psum (psum[n+1])
        );
    end

    // ReLU and saturation
    logic [ACT_W-1:0] act;

    always_comb begin
        if (psum[KS][SUM_W-1]) begin
            act = '0;
        end else if (psum[KS] > SUM_W'(c3r_pkg::ACT_MAX)) begin
            act = ACT_W'(c3r_pkg::ACT_MAX);
        end else begin
            act = psum[KS][ACT_W-1:0];
        end
    end

    // output register with skid slot
    logic             r_out_valid, r_out_last, r_skid_last;
    logic [ACT_W-1:0] r_out_act, r_skid_act;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (m_axis_tready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (r_vb) begin
            if (r_out_valid && !m_axis_tready) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (m_axis_tready) begin
                r_out_act  <= r_skid_act;
                r_out_last <= r_skid_last;
            end
        end else if (r_vb) begin
            if (r_out_valid && !m_axis_tready) begin
                r_skid_act  <= act;
                r_skid_last <= r_lb;
            end else begin
                r_out_act  <= act;
                r_out_last <= r_lb;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = c3r_pkg::OUT_TDATA_W'(r_out_act);
    assign m_axis_tlast  = r_out_last;

endmodule

>>> src/c3r_checker.sv
`include "conv2d_3x3_relu_stream_assert.svh"

module c3r_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [c3r_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input logic                                m_axis_tlast
);

    // a stalled result must not change
    `C3R_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

    // input back-pressure only follows a stalled output
    `C3R_ASSERT_NOW(a_ready_low, i_clk, !i_rst_n, !s_axis_tready, $past(m_axis_tvalid && !m_axis_tready), "input stalled without output back-pressure")

    // reset empties the output and opens the input
    `C3R_ASSERT_NEXT(a_reset_clears, i_clk, 1'b0, !i_rst_n, !m_axis_tvalid && s_axis_tready, "reset did not clear the stream state")

    // activation stays within the ReLU and saturation range, padding is zero
    `C3R_ASSERT_NOW(a_act_range, i_clk, !i_rst_n, m_axis_tvalid && m_axis_tready, (m_axis_tdata <= c3r_pkg::OUT_TDATA_W'(c3r_pkg::ACT_MAX)), "activation out of range")

endmodule

bind conv2d_3x3_relu_stream c3r_checker u_c3r_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
);

>>> sim/conv2d_3x3_relu_stream_tb.sv
`timescale 1ns / 1ps

module conv2d_3x3_relu_stream_tb;

    localparam int          MAX_SIDE      = 1024;
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int          RAND_ITEMS    = 580;
    localparam int          RAND_SIDE_MAX = 10;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_CHOKE} t_rx_mode;
    typedef enum logic {DIR_CFG, DIR_PIX} t_dir_op;

    typedef struct packed {
        logic [c3r_pkg::ACT_W-1:0] act;
        logic                      lst;
    } t_act;

    typedef struct {
        t_dir_op                   op;
        c3r_pkg::t_cfg_reg         idx;
        logic [23:0]               val;
        logic [c3r_pkg::PIX_W-1:0] px;
        bit                        typed;
        t_act                      want;
    } t_dir_row;

    logic                                i_clk         = 1'b0;
    logic                                i_rst_n       = 1'b0;
    logic                                i_cfg_we      = 1'b0;
    logic [c3r_pkg::CFG_IDX_W-1:0]       i_cfg_idx     = '0;
    logic [c3r_pkg::CFG_DATA_W-1:0]      i_cfg_wdata   = '0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [c3r_pkg::IN_TDATA_W-1:0]      s_axis_tdata  = '0;   // [7:0] pixel
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [c3r_pkg::OUT_TDATA_W-1:0]     m_axis_tdata;   // [17:0] activation, rest 0
    logic                                m_axis_tlast;

    conv2d_3x3_relu_stream #(.MAX_SIDE(MAX_SIDE)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // local copy of the block state
    logic [c3r_pkg::PIX_W-1:0]  line_a [MAX_SIDE];
    logic [c3r_pkg::PIX_W-1:0]  line_b [MAX_SIDE];
    logic [c3r_pkg::PIX_W-1:0]  win [c3r_pkg::KERNEL_SIDE][c3r_pkg::KERNEL_SIDE];
    int unsigned                col_pos;
    int unsigned                row_pos;
    logic [23:0]                w_row [c3r_pkg::KERNEL_SIDE];
    logic [c3r_pkg::SIZE_W-1:0] size_reg;

    t_act        pending_acts [$];
    t_dir_row    dir_tab [$];
    int unsigned err_cnt    = 0;
    int unsigned cycle_cnt  = 0;
    int unsigned burst_left = 0;
    int unsigned rand_items = 0;
    t_rx_mode    rx_mode    = RX_OPEN;
    int unsigned rx_left    = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        err_cnt++;
    endtask

    function automatic int unsigned eff_side();
        if (size_reg < 3) return 3;
        if (size_reg > MAX_SIDE) return MAX_SIDE;
        return size_reg;
    endfunction

    function automatic bit predict_activation(input logic [c3r_pkg::PIX_W-1:0] px,
                                              output t_act res);
        int unsigned               side;
        int unsigned               c;
        int unsigned               r;
        int                        acc;
        int                        w;
        logic [c3r_pkg::PIX_W-1:0] up2;
        logic [c3r_pkg::PIX_W-1:0] up1;
        bit                        hit;
        side = eff_side();
        c    = col_pos;
        r    = row_pos;
        up2  = line_b[c];
        up1  = line_a[c];
        line_b[c] = up1;
        line_a[c] = px;
        for (int m = 0; m < c3r_pkg::KERNEL_SIDE; m++) begin
            win[m][0] = win[m][1];
            win[m][1] = win[m][2];
        end
        win[0][2] = up2;
        win[1][2] = up1;
        win[2][2] = px;
        res = '0;
        hit = (r >= 2) && (c >= 2);
        if (hit) begin
            acc = 0;
            for (int m = 0; m < c3r_pkg::KERNEL_SIDE; m++) begin
                for (int n = 0; n < c3r_pkg::KERNEL_SIDE; n++) begin
                    w = $signed(w_row[m][8*n +: 8]);
                    acc += int'(win[m][n]) * w;
                end
            end
            if (acc < 0) acc = 0;
            else if (acc > c3r_pkg::ACT_MAX) acc = c3r_pkg::ACT_MAX;
            res.act = acc[c3r_pkg::ACT_W-1:0];
            res.lst = (r >= side - 1) && (c >= side - 1);
        end
        // raster advance; a lowered side wraps at the next pixel
        if (c >= side - 1) begin
            col_pos = 0;
            row_pos = (r >= side - 1) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
        return hit;
    endfunction

    task automatic write_reg(input c3r_pkg::t_cfg_reg idx, input logic [23:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            c3r_pkg::REG_WEIGHTS_ROW0,
            c3r_pkg::REG_WEIGHTS_ROW1,
            c3r_pkg::REG_WEIGHTS_ROW2: w_row[idx] = val;
            c3r_pkg::REG_IMAGE_SIZE:   size_reg = val[c3r_pkg::SIZE_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // stop input, let every expected result out, then cover pixels still in flight
    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        while (pending_acts.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic send_pixel(input logic [c3r_pkg::PIX_W-1:0] px, input bit typed,
                              input t_act typed_want);
        t_act        res;
        bit          got;
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        got = predict_activation(px, res);
        if (typed) pending_acts.push_back(typed_want);
        else if (got) pending_acts.push_back(res);
    endtask

    function automatic logic [23:0] rand_weights();
        logic [23:0] w;
        w = 24'($urandom);
        case ($urandom_range(0, 5))
            0: w = w & 24'h7F7F7F;   // non-negative kernel, drives saturation
            1: w = w | 24'h808080;   // negative kernel, drives the ReLU clamp
            2: w = 24'h7F7F7F;
            3: w = 24'h808080;
            default: ;
        endcase
        return w;
    endfunction

    function automatic logic [c3r_pkg::PIX_W-1:0] rand_pixel();
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic t_dir_row cfg_row(input c3r_pkg::t_cfg_reg idx,
                                         input logic [23:0] val);
        t_dir_row row;
        row = '{op: DIR_CFG, idx: idx, val: val, px: '0, typed: 1'b0, want: '0};
        return row;
    endfunction

    function automatic t_dir_row pix_row(input logic [c3r_pkg::PIX_W-1:0] px);
        t_dir_row row;
        row = '{op: DIR_PIX, idx: c3r_pkg::REG_WEIGHTS_ROW0, val: '0, px: px,
                typed: 1'b0, want: '0};
        return row;
    endfunction

    function automatic t_dir_row chk_row(input logic [c3r_pkg::PIX_W-1:0] px,
                                         input logic [c3r_pkg::ACT_W-1:0] act,
                                         input logic lst);
        t_dir_row row;
        row = '{op: DIR_PIX, idx: c3r_pkg::REG_WEIGHTS_ROW0, val: '0, px: px,
                typed: 1'b1, want: '{act: act, lst: lst}};
        return row;
    endfunction

    // receiver: switches between random stall patterns
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(30, 200);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_OPEN:     m_axis_tready <= 1'b1;
            RX_COIN:     m_axis_tready <= ($urandom_range(0, 1) == 1);
            RX_PERIODIC: m_axis_tready <= ((rx_left % 4) == 0);
            default:     m_axis_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_act want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_acts.size() == 0) begin
                report_mismatch("result with nothing expected",
                                int'(m_axis_tdata[c3r_pkg::ACT_W-1:0]), -1);
            end else begin
                want = pending_acts.pop_front();
                if (m_axis_tdata[c3r_pkg::ACT_W-1:0] !== want.act)
                    report_mismatch("activation", int'(m_axis_tdata[c3r_pkg::ACT_W-1:0]),
                                    int'(want.act));
                if (m_axis_tlast !== want.lst)
                    report_mismatch("tlast", int'(m_axis_tlast), int'(want.lst));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("conv2d_3x3_relu_stream_tb: errors");
            $finish;
        end
    end

    initial begin
        int unsigned n;
        int unsigned side;
        foreach (line_a[i]) begin
            line_a[i] = '0;
            line_b[i] = '0;
        end
        foreach (win[m, k]) win[m][k] = '0;
        foreach (w_row[i]) w_row[i] = '0;
        col_pos  = 0;
        row_pos  = 0;
        size_reg = 5;

        // reset values: zero kernel, side 5; first result at row 2, column 2
        dir_tab.push_back(pix_row(8'h00));
        dir_tab.push_back(pix_row(8'hFF));
        dir_tab.push_back(pix_row(8'h01));
        dir_tab.push_back(pix_row(8'h80));
        dir_tab.push_back(pix_row(8'h7F));
        dir_tab.push_back(pix_row(8'hFE));
        dir_tab.push_back(pix_row(8'h55));
        dir_tab.push_back(pix_row(8'hAA));
        dir_tab.push_back(pix_row(8'h0F));
        dir_tab.push_back(pix_row(8'hF0));
        dir_tab.push_back(pix_row(8'h33));
        dir_tab.push_back(pix_row(8'hCC));
        dir_tab.push_back(chk_row(8'hFF, '0, 1'b0));
        // side below range clamps to 3, and the shrink closes the frame at once
        dir_tab.push_back(cfg_row(c3r_pkg::REG_IMAGE_SIZE, 24'd0));
        dir_tab.push_back(chk_row(8'h00, '0, 1'b1));
        // largest positive kernel on a white frame saturates
        dir_tab.push_back(cfg_row(c3r_pkg::REG_WEIGHTS_ROW0, 24'h7F7F7F));
        dir_tab.push_back(cfg_row(c3r_pkg::REG_WEIGHTS_ROW1, 24'h7F7F7F));
        dir_tab.push_back(cfg_row(c3r_pkg::REG_WEIGHTS_ROW2, 24'h7F7F7F));
        repeat (8) dir_tab.push_back(pix_row(8'hFF));
        dir_tab.push_back(chk_row(8'hFF, c3r_pkg::ACT_W'(c3r_pkg::ACT_MAX), 1'b1));
        // most negative kernel: ReLU gives zero
        dir_tab.push_back(cfg_row(c3r_pkg::REG_WEIGHTS_ROW0, 24'h808080));
        dir_tab.push_back(cfg_row(c3r_pkg::REG_WEIGHTS_ROW1, 24'h808080));
        dir_tab.push_back(cfg_row(c3r_pkg::REG_WEIGHTS_ROW2, 24'h808080));
        repeat (8) dir_tab.push_back(pix_row(8'hFF));
        dir_tab.push_back(chk_row(8'hFF, '0, 1'b1));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].op == DIR_CFG) begin
                drain_pipeline();
                write_reg(dir_tab[i].idx, dir_tab[i].val);
            end else begin
                send_pixel(dir_tab[i].px, dir_tab[i].typed, dir_tab[i].want);
            end
        end

        // a few rows at the widest side used below, from a frame boundary: writes
        // every line-store entry that later side changes can read
        drain_pipeline();
        write_reg(c3r_pkg::REG_WEIGHTS_ROW0, rand_weights());
        write_reg(c3r_pkg::REG_WEIGHTS_ROW1, rand_weights());
        write_reg(c3r_pkg::REG_WEIGHTS_ROW2, rand_weights());
        write_reg(c3r_pkg::REG_IMAGE_SIZE, 24'(RAND_SIDE_MAX));
        n = 3 * RAND_SIDE_MAX + $urandom_range(4, 12);
        repeat (n) send_pixel(rand_pixel(), 1'b0, '0);
        drain_pipeline();
        write_reg(c3r_pkg::REG_IMAGE_SIZE, 24'($urandom_range(0, 2)));

        while (rand_items < RAND_ITEMS) begin
            drain_pipeline();
            if ($urandom_range(0, 1)) write_reg(c3r_pkg::REG_WEIGHTS_ROW0, rand_weights());
            if ($urandom_range(0, 1)) write_reg(c3r_pkg::REG_WEIGHTS_ROW1, rand_weights());
            if ($urandom_range(0, 1)) write_reg(c3r_pkg::REG_WEIGHTS_ROW2, rand_weights());
            if ($urandom_range(0, 1)) begin
                if ($urandom_range(0, 7) == 0)
                    write_reg(c3r_pkg::REG_IMAGE_SIZE, 24'($urandom_range(0, 2)));
                else
                    write_reg(c3r_pkg::REG_IMAGE_SIZE,
                              24'($urandom_range(3, RAND_SIDE_MAX)));
            end
            side = eff_side();
            // mostly finish the frame; otherwise a short run that breaks it off
            if ($urandom_range(0, 3) != 0 && row_pos < side && col_pos < side)
                n = (side - 1 - row_pos) * side + (side - col_pos);
            else
                n = $urandom_range(1, 12);
            repeat (n) begin
                send_pixel(rand_pixel(), 1'b0, '0);
                rand_items++;
            end
        end

        drain_pipeline();
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0)
            $display("conv2d_3x3_relu_stream_tb: clean");
        else
            $display("conv2d_3x3_relu_stream_tb: errors");
        $finish;
    end

endmodule
